// ----- hw/rtl/cpst_pkg.sv -----
// shared constants and types for the corner point suppression table
package cpst_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 11;

    // depth of the queues between front, back and result port
    localparam int QUEUE_DEPTH = 2;

    // register reset values
    localparam logic [7:0] MIN_RESPONSE_RST   = 8'd100;
    localparam logic [6:0] POINT_DIAMETER_RST = 7'd6;

    // register index, taken from paddr[2]
    localparam logic REG_MIN_RESPONSE   = 1'b0;
    localparam logic REG_POINT_DIAMETER = 1'b1;

    // width of the squared diameter
    localparam int LIM_W = 14;

    typedef enum logic [2:0] {
        ACT_BELOW      = 3'd0,
        ACT_SUPPRESSED = 3'd1,
        ACT_REPLACED   = 3'd2,
        ACT_APPENDED   = 3'd3,
        ACT_DROPPED    = 3'd4
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] slot;
        logic [8:0] point_count;
    } t_result;

endpackage

// ----- hw/rtl/corner_point_suppression_table_core.sv -----
// top level of the corner point suppression table with its register port
//
// pixels come in on a queue-style port: a transfer happens when push is high
// and full is low. start_frame, col, row and response travel with each pixel
// results leave on a queue-style port: the oldest result sits on o_action,
// o_slot and o_point_count while empty is low, and pop takes it
// exactly one result per pixel, in pixel order
// a pixel at or below min_response passes the back end without a table scan;
// one above it is checked against every stored point: the back end reads
// one table entry per cycle from its single read port and two pipeline
// stages settle the distance test. a replacement ends the scan as soon as
// the weaker point is found
// a two-entry queue sits in front of the back end and another holds results,
// so pixels keep being taken while a result waits; when pop stays low the
// result queue fills, the back end stops and full rises once the input queue
// is full. nothing is lost
// reset empties the table (point count zero), both queues and loads
// min_response with 100 and point_diameter with 6; no clearing pass is needed
// registers: min_response at address 0, point_diameter at address 4
module corner_point_suppression_table_core #(
    parameter int MAX_POINTS = cpst_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = cpst_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // pixel queue
    input  logic                  push,
    output logic                  full,
    input  logic                  i_start_frame,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [7:0]            i_response,
    // result queue
    output logic                  empty,
    input  logic                  pop,
    output logic [2:0]            o_action,
    output logic [7:0]            o_slot,
    output logic [8:0]            o_point_count
);
    import cpst_pkg::*;

    localparam int ITEM_W = 2 * COORD_BITS + 10;

    logic [7:0]        r_min_response;
    logic [6:0]        r_point_diameter;
    logic              w_cfg_wr;
    logic              w_q_empty, w_q_pop;
    logic [ITEM_W-1:0] w_q_data;
    t_result           w_res;

    // register writes complete on the access phase, no wait states
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_response   <= MIN_RESPONSE_RST;
            r_point_diameter <= POINT_DIAMETER_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_MIN_RESPONSE:   r_min_response   <= pwdata[7:0];
                REG_POINT_DIAMETER: r_point_diameter <= pwdata[6:0];
                default:            r_min_response   <= r_min_response;
            endcase
        end
    end

    // read back, byte lanes within a register are not decoded
    always_comb begin
        unique case (paddr[2])
            REG_MIN_RESPONSE:   prdata = {24'd0, r_min_response};
            REG_POINT_DIAMETER: prdata = {25'd0, r_point_diameter};
            default:            prdata = '0;
        endcase
    end

    // front: threshold test and input queue
    cpst_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_start_frame  (i_start_frame),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_response     (i_response),
        .i_min_response (r_min_response),
        .o_q_empty      (w_q_empty),
        .i_q_pop        (w_q_pop),
        .o_q_data       (w_q_data)
    );

    // back: table scan, update and result queue
    cpst_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_q_empty),
        .o_q_pop          (w_q_pop),
        .i_q_data         (w_q_data),
        .i_point_diameter (r_point_diameter),
        .o_res_empty      (empty),
        .i_res_pop        (pop),
        .o_res            (w_res)
    );

    assign o_action      = w_res.action;
    assign o_slot        = w_res.slot;
    assign o_point_count = w_res.point_count;

endmodule

// ----- hw/rtl/cpst_fifo.sv -----
// small synchronous queue with registered storage
module cpst_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/cpst_front.sv -----
// front end: accepts pixels, applies the response threshold, queues them
module cpst_front #(
    parameter int COORD_BITS = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_start_frame,
    input  logic [COORD_BITS-1:0]   i_col,
    input  logic [COORD_BITS-1:0]   i_row,
    input  logic [7:0]              i_response,
    input  logic [7:0]              i_min_response,
    output logic                    o_q_empty,
    input  logic                    i_q_pop,
    output logic [2*COORD_BITS+9:0] o_q_data
);
    import cpst_pkg::*;

    localparam int ITEM_W = 2 * COORD_BITS + 10;

    logic              w_above;
    logic [ITEM_W-1:0] w_item;

    // layout: start, above, col, row, response
    assign w_above = (i_response > i_min_response);
    assign w_item  = {i_start_frame, w_above, i_col, i_row, i_response};

    cpst_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_item),
        .o_full  (full),
        .i_pop   (i_q_pop),
        .o_data  (o_q_data),
        .o_empty (o_q_empty)
    );

endmodule

// ----- hw/rtl/cpst_back.sv -----
// back end: scans the point table, updates it and queues the result
module cpst_back #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_empty,
    output logic                    o_q_pop,
    input  logic [2*COORD_BITS+9:0] i_q_data,
    input  logic [6:0]              i_point_diameter,
    output logic                    o_res_empty,
    input  logic                    i_res_pop,
    output cpst_pkg::t_result       o_res
);
    import cpst_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int ITEM_W = 2 * C + 10;
    localparam int ENT_W  = 2 * C + 8;
    localparam int SLOT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SQ_W   = 2 * C;
    localparam int SUM_W  = SQ_W + 1;
    localparam int CMP_W  = (SUM_W > LIM_W) ? SUM_W : LIM_W;
    localparam int SX_W   = SLOT_W + 8;
    localparam int NX_W   = CNT_W + 9;
    localparam int RES_W  = $bits(t_result);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [C-1:0]      r_col, n_col;
    logic [C-1:0]      r_row, n_row;
    logic [7:0]        r_resp, n_resp;
    logic [LIM_W-1:0]  r_lim, n_lim;
    logic              r_ovl, n_ovl;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_rd_vld, n_rd_vld;
    logic [SLOT_W-1:0] r_a_idx, n_a_idx;
    logic              r_b_vld, n_b_vld;
    logic [SLOT_W-1:0] r_b_idx, n_b_idx;
    logic [SQ_W-1:0]   r_b_sqc, n_b_sqc;
    logic [SQ_W-1:0]   r_b_sqr, n_b_sqr;
    logic              r_b_stronger, n_b_stronger;

    logic [ENT_W-1:0]  r_mem [MAX_POINTS];
    logic [ENT_W-1:0]  r_mem_q;

    logic [C-1:0]      w_ent_col, w_ent_row, w_dc, w_dr;
    logic [7:0]        w_ent_str;
    logic [SQ_W-1:0]   w_sqc, w_sqr;
    logic [SUM_W-1:0]  w_sum;
    logic              w_b_ovl, w_hit, w_issue, w_drained;
    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    logic [ENT_W-1:0]  w_wdata;
    logic              w_res_push, w_res_full;
    t_action           w_act;
    logic [SLOT_W-1:0] w_slot;
    logic [SX_W-1:0]   w_slot_x;
    logic [NX_W-1:0]   w_cnt_x;
    t_result           w_res;
    logic [RES_W-1:0]  w_res_q;

    // stage a: distance terms of the entry read last cycle
    assign w_ent_col = r_mem_q[ENT_W-1 -: C];
    assign w_ent_row = r_mem_q[C+7 -: C];
    assign w_ent_str = r_mem_q[7:0];
    assign w_dc  = (r_col > w_ent_col) ? r_col - w_ent_col : w_ent_col - r_col;
    assign w_dr  = (r_row > w_ent_row) ? r_row - w_ent_row : w_ent_row - r_row;
    assign w_sqc = SQ_W'(w_dc) * SQ_W'(w_dc);
    assign w_sqr = SQ_W'(w_dr) * SQ_W'(w_dr);

    // stage b: overlap test
    assign w_sum     = SUM_W'(r_b_sqc) + SUM_W'(r_b_sqr);
    assign w_b_ovl   = r_b_vld && (CMP_W'(w_sum) < CMP_W'(r_lim));
    assign w_hit     = w_b_ovl && r_b_stronger;
    assign w_issue   = (r_rd_idx < r_cnt);
    assign w_drained = !w_issue && !r_rd_vld && !r_b_vld;
    assign w_wdata   = {r_col, r_row, r_resp};

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_col        = r_col;
        n_row        = r_row;
        n_resp       = r_resp;
        n_lim        = r_lim;
        n_ovl        = r_ovl;
        n_rd_idx     = r_rd_idx;
        n_rd_vld     = 1'b0;
        n_a_idx      = r_a_idx;
        n_b_vld      = 1'b0;
        n_b_idx      = r_b_idx;
        n_b_sqc      = r_b_sqc;
        n_b_sqr      = r_b_sqr;
        n_b_stronger = r_b_stronger;
        o_q_pop      = 1'b0;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_res_push   = 1'b0;
        w_act        = ACT_BELOW;
        w_slot       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty && !w_res_full) begin
                    o_q_pop = 1'b1;
                    n_cnt   = i_q_data[ITEM_W-1] ? '0 : r_cnt;
                    n_col   = i_q_data[ENT_W-1 -: C];
                    n_row   = i_q_data[C+7 -: C];
                    n_resp  = i_q_data[7:0];
                    if (!i_q_data[ITEM_W-2]) begin
                        w_res_push = 1'b1;
                    end else begin
                        n_state  = S_SCAN;
                        n_rd_idx = '0;
                        n_ovl    = 1'b0;
                        n_lim    = LIM_W'(i_point_diameter) * LIM_W'(i_point_diameter);
                    end
                end
            end
            S_SCAN: begin
                n_rd_vld     = w_issue;
                n_a_idx      = r_rd_idx[SLOT_W-1:0];
                n_b_vld      = r_rd_vld;
                n_b_idx      = r_a_idx;
                n_b_sqc      = w_sqc;
                n_b_sqr      = w_sqr;
                n_b_stronger = (r_resp > w_ent_str);
                if (w_issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (w_hit) begin
                    // first weaker overlapping point: overwrite it and stop
                    w_we       = 1'b1;
                    w_waddr    = r_b_idx;
                    w_res_push = 1'b1;
                    w_act      = ACT_REPLACED;
                    w_slot     = r_b_idx;
                    n_rd_vld   = 1'b0;
                    n_b_vld    = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    if (w_b_ovl) begin
                        n_ovl = 1'b1;
                    end
                    if (w_drained) begin
                        n_state    = S_IDLE;
                        w_res_push = 1'b1;
                        if (r_ovl) begin
                            w_act = ACT_SUPPRESSED;
                        end else if (r_cnt < CNT_W'(MAX_POINTS)) begin
                            w_we    = 1'b1;
                            w_waddr = r_cnt[SLOT_W-1:0];
                            n_cnt   = r_cnt + 1'b1;
                            w_act   = ACT_APPENDED;
                            w_slot  = r_cnt[SLOT_W-1:0];
                        end else begin
                            w_act = ACT_DROPPED;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_slot_x          = SX_W'(w_slot);
    assign w_cnt_x           = NX_W'(n_cnt);
    assign w_res.action      = w_act;
    assign w_res.slot        = w_slot_x[7:0];
    assign w_res.point_count = w_cnt_x[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_b_vld  <= 1'b0;
            r_ovl    <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= n_rd_vld;
            r_b_vld  <= n_b_vld;
            r_ovl    <= n_ovl;
            r_rd_idx <= n_rd_idx;
        end
        r_col        <= n_col;
        r_row        <= n_row;
        r_resp       <= n_resp;
        r_lim        <= n_lim;
        r_a_idx      <= n_a_idx;
        r_b_idx      <= n_b_idx;
        r_b_sqc      <= n_b_sqc;
        r_b_sqr      <= n_b_sqr;
        r_b_stronger <= n_b_stronger;
    end

    // point table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_mem_q <= r_mem[r_rd_idx[SLOT_W-1:0]];
    end

    cpst_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (i_res_pop),
        .o_data  (w_res_q),
        .o_empty (o_res_empty)
    );

    assign o_res = t_result'(w_res_q);

endmodule

// ----- tb/tb_corner_point_suppression_table_core.sv -----
// self-checking testbench for the corner point suppression table core
module tb_corner_point_suppression_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cpst_pkg::*;

    localparam int CW           = COORD_BITS_DEF;
    localparam int TABLE_DEPTH  = MAX_POINTS_DEF;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    // each side waits a random gap of up to IDLE_MAX before a transfer
    localparam int IDLE_MAX     = 13;
    // a full table scan plus both idle draws on top of it stays far below the
    // watchdog limit
    localparam int STALL_LIMIT  = 20000;
    // settling time once every result has come, about one full scan
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_PIXELS  = 115;

    localparam logic [2:0] ADDR_MIN_RESPONSE   = {REG_MIN_RESPONSE, 2'b00};
    localparam logic [2:0] ADDR_POINT_DIAMETER = {REG_POINT_DIAMETER, 2'b00};

    // clock, reset and every block input start at a known value
    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          psel          = 1'b0;
    logic          penable       = 1'b0;
    logic          pwrite        = 1'b0;
    logic [2:0]    paddr         = '0;
    logic [31:0]   pwdata        = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          push          = 1'b0;
    logic          full;
    logic          i_start_frame = 1'b0;
    logic [CW-1:0] i_col         = '0;
    logic [CW-1:0] i_row         = '0;
    logic [7:0]    i_response    = '0;
    logic          empty;
    logic          pop           = 1'b0;
    logic [2:0]    o_action;
    logic [7:0]    o_slot;
    logic [8:0]    o_point_count;

    // predictor copy of the point table and of both registers
    logic [CW-1:0] kept_col      [TABLE_DEPTH];
    logic [CW-1:0] kept_row      [TABLE_DEPTH];
    logic [7:0]    kept_strength [TABLE_DEPTH];
    int            kept_count    = 0;
    logic [7:0]    cfg_min_response = MIN_RESPONSE_RST;
    logic [6:0]    cfg_diameter     = POINT_DIAMETER_RST;

    // verdicts still owed by the block, oldest first
    t_result       expected_verdicts[$];
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles   = 0;
    bit            send_burst     = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    corner_point_suppression_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .i_start_frame (i_start_frame),
        .i_col         (i_col),
        .i_row         (i_row),
        .i_response    (i_response),
        .empty         (empty),
        .pop           (pop),
        .o_action      (o_action),
        .o_slot        (o_slot),
        .o_point_count (o_point_count)
    );

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // greedy suppression of one pixel against the kept points, in slot order;
    // the verdict joins the queue of owed results
    function automatic void classify_pixel(input bit sf, input logic [CW-1:0] c,
                                           input logic [CW-1:0] r,
                                           input logic [7:0] resp);
        t_result verdict;
        int      lim;
        int      dc;
        int      dr;
        bit      overlap;
        bit      replaced;
        verdict.action = ACT_BELOW;
        verdict.slot   = '0;
        overlap  = 1'b0;
        replaced = 1'b0;
        // start of frame empties the table even when the pixel is too weak
        if (sf)
            kept_count = 0;
        if (resp > cfg_min_response) begin
            lim = int'(cfg_diameter) * int'(cfg_diameter);
            for (int i = 0; i < kept_count; i++) begin
                dc = int'(c) - int'(kept_col[i]);
                dr = int'(r) - int'(kept_row[i]);
                if (dc * dc + dr * dr < lim) begin
                    overlap = 1'b1;
                    // only a strictly weaker neighbour gives way
                    if (resp > kept_strength[i]) begin
                        kept_col[i]      = c;
                        kept_row[i]      = r;
                        kept_strength[i] = resp;
                        verdict.slot     = 8'(i);
                        replaced         = 1'b1;
                        break;
                    end
                end
            end
            if (replaced) begin
                verdict.action = ACT_REPLACED;
            end else if (overlap) begin
                verdict.action = ACT_SUPPRESSED;
            end else if (kept_count < TABLE_DEPTH) begin
                verdict.action           = ACT_APPENDED;
                verdict.slot             = 8'(kept_count);
                kept_col[kept_count]      = c;
                kept_row[kept_count]      = r;
                kept_strength[kept_count] = resp;
                kept_count++;
            end else begin
                // no room left: the pixel is flagged and thrown away
                verdict.action = ACT_DROPPED;
            end
        end
        verdict.point_count = 9'(kept_count);
        expected_verdicts = {expected_verdicts, verdict};
    endfunction

    // a response that clears the current threshold, any value when none can
    function automatic logic [7:0] strong_response();
        if (cfg_min_response == 8'd255)
            return 8'($urandom);
        return 8'($urandom_range(int'(cfg_min_response) + 1, 255));
    endfunction

    // one pixel transfer after a random gap; bursts of back-to-back pixels come
    // and go at random so that gaps land on every phase of the table scan
    task automatic send_pixel(input bit sf, input logic [CW-1:0] c,
                              input logic [CW-1:0] r, input logic [7:0] resp);
        int gap;
        if ($urandom_range(0, 63) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_start_frame <= sf;
        i_col         <= c;
        i_row         <= r;
        i_response    <= resp;
        do @(posedge i_clk); while (full);
        classify_pixel(sf, c, r, resp);
    endtask

    // stop sending and hold until every owed result has been taken
    task automatic wait_for_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    // register write in setup and access cycles, then a read back
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_MIN_RESPONSE)
            cfg_min_response = value[7:0];
        else
            cfg_diameter = value[6:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_MIN_RESPONSE && prdata[7:0] !== cfg_min_response)
            report_mismatch($sformatf("min_response reads %0d, written %0d",
                                      prdata[7:0], cfg_min_response));
        if (addr == ADDR_POINT_DIAMETER && prdata[6:0] !== cfg_diameter)
            report_mismatch($sformatf("point_diameter reads %0d, written %0d",
                                      prdata[6:0], cfg_diameter));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // registers change only once the block has nothing left in flight
    task automatic set_config(input logic [7:0] min_resp, input logic [6:0] diam);
        wait_for_results();
        write_reg(ADDR_MIN_RESPONSE, {24'd0, min_resp});
        write_reg(ADDR_POINT_DIAMETER, {25'd0, diam});
    endtask

    // hand-picked pixels: field extremes, every action and the boundary cases
    task automatic test_directed_cases();
        // reset settings: threshold 100, diameter 6
        send_pixel(1'b1, 11'd0, 11'd0, 8'd255);         // first point, strongest
        send_pixel(1'b0, 11'd2047, 11'd2047, 8'd101);   // just above threshold
        send_pixel(1'b0, 11'd1, 11'd1, 8'd100);         // at threshold, ignored
        send_pixel(1'b0, 11'd2, 11'd2, 8'd200);         // overlaps a stronger point
        send_pixel(1'b0, 11'd2045, 11'd2047, 8'd150);   // replaces a weaker point
        send_pixel(1'b0, 11'd6, 11'd0, 8'd200);         // distance equals diameter
        send_pixel(1'b1, 11'd0, 11'd0, 8'd0);           // weak start of frame still clears
        send_pixel(1'b0, 11'd1024, 11'd1024, 8'd255);
        // zero diameter: nothing overlaps, even the very same pixel
        set_config(8'd0, 7'd0);
        send_pixel(1'b0, 11'd1024, 11'd1024, 8'd1);
        send_pixel(1'b0, 11'd1024, 11'd1024, 8'd0);     // zero never beats threshold zero
        set_config(8'd255, 7'd0);
        send_pixel(1'b0, 11'd5, 11'd5, 8'd255);         // nothing passes threshold 255
        // diameter far beyond the usual range
        set_config(8'd0, 7'd127);
        send_pixel(1'b1, 11'd0, 11'd0, 8'd50);
        send_pixel(1'b0, 11'd89, 11'd89, 8'd60);        // just inside, replaces
        send_pixel(1'b0, 11'd2047, 11'd0, 8'd10);
        send_pixel(1'b0, 11'd2000, 11'd100, 8'd5);      // inside, weaker: suppressed
        // smallest useful diameter: only the same pixel overlaps
        set_config(8'd10, 7'd1);
        send_pixel(1'b1, 11'd7, 11'd9, 8'd80);
        send_pixel(1'b0, 11'd7, 11'd9, 8'd80);          // equal strength does not replace
        send_pixel(1'b0, 11'd8, 11'd9, 8'd90);          // one pixel away, appended
        send_pixel(1'b0, 11'd7, 11'd9, 8'd81);
        send_pixel(1'b0, 11'd7, 11'd9, 8'd11);          // one above threshold
    endtask

    // fill the table to the brim, then keep hitting it while it is full
    task automatic test_table_full();
        int            j;
        logic [CW-1:0] c;
        logic [CW-1:0] r;
        set_config(8'd0, 7'd0);
        send_pixel(1'b1, 11'($urandom), 11'($urandom), strong_response());
        for (int n = 0; n < TABLE_DEPTH + 8; n++)
            send_pixel(1'b0, 11'($urandom), 11'($urandom), 8'($urandom));
        // a real diameter on the full table: neighbours replace or get
        // suppressed, loners are dropped
        set_config(8'd50, 7'd3);
        for (int n = 0; n < 40; n++) begin
            if ($urandom_range(0, 1) == 0) begin
                j = $urandom_range(0, kept_count - 1);
                c = kept_col[j] + 11'($urandom_range(0, 2));
                r = kept_row[j] + 11'($urandom_range(0, 2));
            end else begin
                c = 11'($urandom);
                r = 11'($urandom);
            end
            send_pixel(1'b0, c, r, 8'($urandom));
        end
    endtask

    // frames of clustered pixels under a range of settings; mostly clusters
    // that overlap at the configured diameter, with noise and weak pixels
    task automatic test_random_frames();
        int            budget;
        int            frame_left;
        int            span;
        int            kind;
        logic [7:0]    min_resp;
        logic [6:0]    diam;
        logic [CW-1:0] base_c;
        logic [CW-1:0] base_r;
        logic [CW-1:0] c;
        logic [CW-1:0] r;
        logic [7:0]    resp;
        bit            sf;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       min_resp = 8'd0;
                1:       min_resp = 8'd255;
                default: min_resp = 8'($urandom_range(0, 200));
            endcase
            case ($urandom_range(0, 7))
                0:       diam = 7'd0;
                1:       diam = 7'd1;
                2:       diam = 7'd64;
                3:       diam = 7'd127;
                default: diam = 7'($urandom_range(2, 20));
            endcase
            set_config(min_resp, diam);
            // threshold 255 ignores everything, so keep that phase short
            budget     = (min_resp == 8'd255) ? 20 : PHASE_PIXELS;
            frame_left = 0;
            span       = 2 * int'(diam) + 3;
            for (int n = 0; n < budget; n++) begin
                sf = 1'b0;
                if (frame_left == 0) begin
                    frame_left = $urandom_range(20, 80);
                    base_c     = 11'($urandom);
                    base_r     = 11'($urandom);
                    sf         = 1'b1;
                end
                frame_left--;
                kind = $urandom_range(0, 9);
                c    = base_c + 11'($urandom_range(0, span));
                r    = base_r + 11'($urandom_range(0, span));
                if (kind == 0) begin
                    // noise: any coordinates, any strength, stray frame starts
                    c    = 11'($urandom);
                    r    = 11'($urandom);
                    resp = 8'($urandom);
                    sf   = sf | ($urandom_range(0, 7) == 0);
                end else if (kind == 1) begin
                    resp = 8'($urandom_range(0, int'(cfg_min_response)));
                end else begin
                    resp = strong_response();
                end
                send_pixel(sf, c, r, resp);
                // once in the run the sender holds off until the block drains
                if (phase == 3 && n == budget / 2)
                    wait_for_results();
            end
        end
    endtask

    // result side: random stalls, each transfer checked against the oldest
    // owed verdict
    initial begin : result_checker
        t_result want;
        int      stall;
        bit      burst;
        burst = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0)
                burst = !burst;
            stall = burst ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("result with nothing owed: action %0d slot %0d",
                                          o_action, o_slot));
            end else begin
                want = expected_verdicts.pop_front();
                if (o_action !== want.action)
                    report_mismatch($sformatf("action %0d, wanted %0d",
                                              o_action, want.action));
                if (o_slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, wanted %0d", o_slot, want.slot));
                if (o_point_count !== want.point_count)
                    report_mismatch($sformatf("point_count %0d, wanted %0d",
                                              o_point_count, want.point_count));
            end
        end
    end

    // watchdog: too long without any transfer on either side ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : test_sequence
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_table_full();
        test_random_frames();
        // drain, then give the block time to show any stray result
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/cpst_pkg.sv
hw/rtl/cpst_fifo.sv
hw/rtl/cpst_front.sv
hw/rtl/cpst_back.sv
hw/rtl/corner_point_suppression_table_core.sv
tb/tb_corner_point_suppression_table_core.sv
